### rtl/core/ilfr_pkg.sv
// ----------------------------------------------------------------------------
// ilfr_pkg: shared types and constants for the idle-line frame receiver
// Buffer sizing, echo phase encoding, echo control struct, digit arithmetic, text tables.
// ----------------------------------------------------------------------------
package ilfr_pkg;

  localparam int BUFFER_DEPTH = 128;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  // two banks: one collects, the other holds the frame being echoed
  localparam int MEM_DEPTH    = 2 * (2 ** ADDR_W);

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_DIGITS,
    PH_SEP,
    PH_DATA,
    PH_CR,
    PH_LF
  } phase_t;

  typedef struct packed {
    logic              emit;
    logic [7:0]        ch;
    logic              last;
    logic              from_mem;
    logic [ADDR_W-1:0] rd_idx;
  } echo_t;

  // v / 10 by reciprocal, exact for v < 1029
  function automatic logic [CNT_W-1:0] div10(input logic [CNT_W-1:0] v);
    logic [CNT_W+7:0] p;
    p = {8'b0, v} * (CNT_W + 8)'(205);
    return CNT_W'(p >> 11);
  endfunction

  function automatic logic [CNT_W-1:0] mul10(input logic [CNT_W-1:0] v);
    return (v << 3) + (v << 1);
  endfunction

  function automatic logic [7:0] head_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h52; // R
      2'd1:    c = 8'h58; // X
      default: c = 8'h5B; // [
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sep_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h5D; // ]
      2'd1:    c = 8'h3A; // :
      default: c = 8'h20; // space
    endcase
    return c;
  endfunction

endpackage

### rtl/core/idle_line_frame_receiver_echo.sv
// ----------------------------------------------------------------------------
// idle_line_frame_receiver_echo: idle-line frame receiver with echo
// Collects bytes into frames closed by line idle and echoes each frame that closes while no echo is pending.
// ----------------------------------------------------------------------------
// An echo byte goes through stage 1 (memory read) and then the output register.
// Throughput: one input transaction per cycle unless in_stall; each one makes
//   at most one write and one read on the single-port-pair byte memory.
// Reset (rst, synchronous): clears counts, frame status, echo sequencer and
//   the pipeline. Byte memory is not cleared; no clearing pass.
module idle_line_frame_receiver_echo (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  input  logic       idle_seen,
  input  logic       overrun_seen,
  input  logic       tx_slot,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       echo_last
);
  import ilfr_pkg::*;

  // Two banks in one memory. rx_bank collects incoming bytes; the other bank
  // holds the frame being echoed. Handover just flips the bank, so no copy.
  logic [7:0]        mem [0:MEM_DEPTH-1];
  logic [7:0]        mem_q;
  logic              rx_bank;
  logic [CNT_W-1:0]  rx_count;
  logic [CNT_W-1:0]  cnt_after;
  logic              store_byte;
  logic              accept;
  logic              handover;
  logic              pending;
  echo_t             echo;

  // stage 1: echo byte with its memory read in flight
  logic              s1_valid;
  logic [7:0]        s1_ch;
  logic              s1_last;
  logic              s1_from_mem;
  logic              out_free;
  logic              s1_move;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  // stall only when stage 1 is full and cannot drain into the output
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  // receive side: byte first, then idle, then overrun
  assign store_byte = byte_valid && (32'(rx_count) < BUFFER_DEPTH);
  assign cnt_after  = store_byte ? rx_count + 1'b1 : rx_count;
  assign handover   = idle_seen && (cnt_after != '0) && !pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count <= '0;
      rx_bank  <= 1'b0;
    end else if (accept) begin
      // idle on a non-empty frame restarts the count, kept or discarded
      if (overrun_seen || (idle_seen && cnt_after != '0)) begin
        rx_count <= '0;
      end else begin
        rx_count <= cnt_after;
      end
      if (handover) begin
        rx_bank <= ~rx_bank;
      end
    end
  end

  // byte memory; echo reads always target the bank opposite rx_bank, so a
  // write and a read never meet on one entry
  always_ff @(posedge clk) begin
    if (accept && store_byte) begin
      mem[{rx_bank, rx_count[ADDR_W-1:0]}] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && echo.emit && echo.from_mem) begin
      mem_q <= mem[{~rx_bank, echo.rd_idx}];
    end
  end

  ilfr_echo_seq u_echo (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .handover   (handover),
    .new_length (cnt_after),
    .tx_slot    (tx_slot),
    .pending    (pending),
    .echo       (echo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= echo.emit;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch       <= echo.ch;
      s1_last     <= echo.last;
      s1_from_mem <= echo.from_mem;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      tx_byte   <= s1_from_mem ? mem_q : s1_ch;
      echo_last <= s1_last;
    end
  end

endmodule

### rtl/core/ilfr_echo_seq.sv
// ----------------------------------------------------------------------------
// ilfr_echo_seq: echo message sequencer
// Holds frame status and walks "RX[len]: data\r\n", one byte per slot.
// ----------------------------------------------------------------------------
module ilfr_echo_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      handover,
  input  logic [ilfr_pkg::CNT_W-1:0] new_length,
  input  logic                      tx_slot,
  output logic                      pending,
  output ilfr_pkg::echo_t           echo
);
  import ilfr_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  phase_t             cur_phase;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   pos_next;
  logic [CNT_W-1:0]   cur_pos;
  logic [CNT_W-1:0]   pos_inc;
  logic [CNT_W-1:0]   frame_length;
  logic [CNT_W-1:0]   q1;
  logic [CNT_W-1:0]   q1_calc;
  logic [CNT_W-1:0]   q2_calc;
  logic [3:0]         ones;
  logic [3:0]         tens;
  logic [3:0]         hundreds;
  logic [1:0]         ndig;
  logic [1:0]         from_end;
  logic [3:0]         digit;

  assign cur_phase = (phase == PH_IDLE) ? PH_HEAD : phase;
  assign cur_pos   = (phase == PH_IDLE) ? '0 : pos;
  assign pos_inc   = cur_pos + 1'b1;

  assign ndig = (32'(frame_length) >= 100) ? 2'd3 :
                (32'(frame_length) >= 10)  ? 2'd2 : 2'd1;

  assign q1_calc = div10(new_length);
  assign q2_calc = div10(q1);

  // length digits: ones and len/10 at handover, split further in the cycle after
  always_ff @(posedge clk) begin
    if (advance && handover) begin
      frame_length <= new_length;
      q1           <= q1_calc;
      ones         <= 4'(new_length - mul10(q1_calc));
    end
    hundreds <= 4'(q2_calc);
    tens     <= 4'(q1 - mul10(q2_calc));
  end

  // next phase and position
  always_comb begin
    phase_next = cur_phase;
    pos_next   = pos_inc;
    case (cur_phase)
      PH_HEAD: begin
        if (cur_pos[1:0] == 2'd2) begin
          phase_next = PH_DIGITS;
          pos_next   = '0;
        end
      end
      PH_DIGITS: begin
        if (pos_inc >= CNT_W'(ndig)) begin
          phase_next = PH_SEP;
          pos_next   = '0;
        end
      end
      PH_SEP: begin
        if (cur_pos[1:0] == 2'd2) begin
          phase_next = PH_DATA;
          pos_next   = '0;
        end
      end
      PH_DATA: begin
        if (pos_inc >= frame_length) begin
          phase_next = PH_CR;
          pos_next   = '0;
        end
      end
      PH_CR: begin
        phase_next = PH_LF;
        pos_next   = cur_pos;
      end
      default: begin
        phase_next = PH_IDLE;
        pos_next   = '0;
      end
    endcase
  end

  // output byte
  always_comb begin
    from_end      = ndig - 2'd1 - cur_pos[1:0];
    digit         = (from_end == 2'd0) ? ones :
                    (from_end == 2'd1) ? tens : hundreds;
    echo.emit     = tx_slot && (pending || handover);
    echo.last     = 1'b0;
    echo.from_mem = 1'b0;
    echo.rd_idx   = cur_pos[ADDR_W-1:0];
    case (cur_phase)
      PH_HEAD:   echo.ch = head_char(cur_pos[1:0]);
      PH_DIGITS: echo.ch = CH_ZERO + {4'b0, digit};
      PH_SEP:    echo.ch = sep_char(cur_pos[1:0]);
      PH_DATA: begin
        echo.ch       = 8'h00;
        echo.from_mem = 1'b1;
      end
      PH_CR:     echo.ch = CH_CR;
      default: begin
        echo.ch   = CH_LF;
        echo.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      pos     <= '0;
      pending <= 1'b0;
    end else if (advance) begin
      if (echo.emit) begin
        phase <= phase_next;
        pos   <= pos_next;
      end
      if (echo.emit && echo.last) begin
        pending <= 1'b0;
      end else if (handover) begin
        pending <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/ilfr_checker.sv
// ----------------------------------------------------------------------------
// ilfr_checker: port-level checks for the idle-line frame receiver
// Watches handshakes and echo framing; bound to the top level.
// ----------------------------------------------------------------------------
module ilfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] tx_byte,
  input logic       echo_last
);
  import ilfr_pkg::*;

  // set when the next output transaction opens a new echo message
  logic msg_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_start <= 1'b1;
    end else if (out_valid && !out_stall) begin
      msg_start <= echo_last;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(echo_last))
    else $error("output changed while stalled");

  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && echo_last |-> tx_byte == CH_LF)
    else $error("echo_last on a byte other than line feed");

  a_msg_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && msg_start |-> tx_byte == 8'h52 && !echo_last)
    else $error("echo message does not open with R");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

endmodule

bind idle_line_frame_receiver_echo ilfr_checker u_ilfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .tx_byte   (tx_byte),
  .echo_last (echo_last)
);
